// ----- design/scd_pkg.sv -----
package scd_pkg;

  localparam int ENTRIES  = 32;
  localparam int SCORE_W  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = IDX_W + 1;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 5;
  localparam int OFS_W    = 3;
  localparam int LOG2_W   = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  typedef logic [SECTOR_W-1:0]       sector_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [OFS_W-1:0]          ofs_t;
  typedef logic [LOG2_W-1:0]         log2_t;
  typedef logic [CFG_AW-1:0]         cfg_addr_t;
  typedef logic [CFG_DW-1:0]         cfg_data_t;
  typedef logic [CFG_AW-3:0]         reg_idx_t;

  localparam reg_idx_t REG_BLOCK_SECTORS_LOG2 = reg_idx_t'(0);
  localparam log2_t    LOG2_RESET             = log2_t'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_RESULT
  } state_t;

  localparam score_t SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // age by one, saturating low
  function automatic score_t score_age(score_t s);
    return (s == SCORE_MIN) ? s : s - score_t'(1);
  endfunction

  // clamp to zero, add two, then age by one
  function automatic score_t score_hit(score_t s);
    score_t sp;
    sp = s[SCORE_W-1] ? score_t'(0) : s;
    return (sp >= SCORE_MAX - score_t'(2)) ? SCORE_MAX - score_t'(1) : sp + score_t'(1);
  endfunction

  // allocation bonus, saturating high
  function automatic score_t score_bump(score_t s);
    return (s >= SCORE_MAX - score_t'(1)) ? SCORE_MAX : s + score_t'(2);
  endfunction

endpackage

// ----- design/scd_cfg.sv -----
module scd_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  scd_pkg::cfg_addr_t paddr,
  input  scd_pkg::cfg_data_t pwdata,
  output scd_pkg::cfg_data_t prdata,
  output logic              pready,
  output scd_pkg::log2_t    blk_log2
);
  import scd_pkg::*;

  log2_t    blk_log2_r;
  reg_idx_t reg_idx;

  assign reg_idx  = paddr[CFG_AW-1:2];
  assign pready   = 1'b1;
  assign blk_log2 = blk_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_log2_r <= LOG2_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_BLOCK_SECTORS_LOG2) begin
      blk_log2_r <= pwdata[LOG2_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_BLOCK_SECTORS_LOG2) begin
      prdata = cfg_data_t'(blk_log2_r);
    end
  end

endmodule

// ----- design/sector_cache_directory_top.sv -----
// Sector cache directory, one request at a time.
// Each accepted request walks all entries (ST_SCAN), allocates on a miss
// (ST_ALLOC) and loads its result in ST_RESULT; the next request is taken once
// the result is loaded. The cost is one walk over all entries, one per cycle,
// through the single read port of the score and tag memories.
// Reset: directory empty, all scores zero, block_sectors_log2 = 3.
module sector_cache_directory_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scd_pkg::sector_t   in_sector,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output scd_pkg::slot_t     out_slot,
  output scd_pkg::ofs_t      out_sector_offset,
  output scd_pkg::sector_t   out_fetch_sector,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  scd_pkg::cfg_addr_t paddr,
  input  scd_pkg::cfg_data_t pwdata,
  output scd_pkg::cfg_data_t prdata,
  output logic               pready
);
  import scd_pkg::*;

  state_t  state_r, state_nxt;
  log2_t   blk_log2;

  sector_t sector_r;
  cnt_t    cnt_r;
  logic    p_vld_r;
  idx_t    p_idx_r;
  logic    hit_r;
  idx_t    match_idx_r;
  ofs_t    match_ofs_r;
  score_t  best_r;
  idx_t    victim_r;

  score_t  score_mem [ENTRIES];
  sector_t tag_mem   [ENTRIES];
  score_t  score_q;
  sector_t tag_q;
  logic [ENTRIES-1:0] ent_vld_r;
  logic [ENTRIES-1:0] sc_init_r;

  logic    out_valid_r;
  logic    out_hit_r;
  slot_t   out_slot_r;
  ofs_t    out_ofs_r;
  sector_t out_fetch_r;

  logic    accept, rd_en, scan_wr, alloc_wr, load_out, last;
  logic    sc_wr_en;
  idx_t    sc_wr_addr;
  score_t  sc_wr_data;

  ofs_t    sh, lo_mask;
  sector_t aligned;
  logic [SECTOR_W:0] diff;
  logic    cur_match;
  score_t  score_eff, new_score;

  scd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .blk_log2 (blk_log2)
  );

  // datapath
  always_comb begin
    sh        = ofs_t'(3'b111) << blk_log2;
    lo_mask   = ~sh;
    aligned   = {sector_r[SECTOR_W-1:OFS_W], sector_r[OFS_W-1:0] & sh};
    diff      = {1'b0, sector_r} - {1'b0, tag_q};
    cur_match = p_vld_r && ent_vld_r[p_idx_r] && !diff[SECTOR_W] &&
                diff[SECTOR_W-1:OFS_W] == '0 && (diff[OFS_W-1:0] & sh) == '0;
    score_eff = sc_init_r[p_idx_r] ? score_q : score_t'(0);
    new_score = cur_match ? score_hit(score_eff) : score_age(score_eff);
    last      = p_vld_r && p_idx_r == idx_t'(ENTRIES-1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (last) state_nxt = (hit_r || cur_match) ? ST_RESULT : ST_ALLOC;
      ST_ALLOC:  state_nxt = ST_RESULT;
      ST_RESULT: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    rd_en    = 1'b0;
    scan_wr  = 1'b0;
    alloc_wr = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_SCAN: begin
        rd_en   = cnt_r < cnt_t'(ENTRIES);
        scan_wr = p_vld_r;
      end
      ST_ALLOC:  alloc_wr = 1'b1;
      ST_RESULT: load_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    sc_wr_en   = scan_wr || alloc_wr;
    sc_wr_addr = alloc_wr ? victim_r : p_idx_r;
    sc_wr_data = alloc_wr ? score_bump(best_r) : new_score;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sector_r <= in_sector;
      cnt_r    <= '0;
      hit_r    <= 1'b0;
    end
    if (rd_en) begin
      cnt_r <= cnt_r + cnt_t'(1);
    end
    p_idx_r <= cnt_r[IDX_W-1:0];
    if (scan_wr) begin
      if (cur_match) begin
        hit_r       <= 1'b1;
        match_idx_r <= p_idx_r;
        match_ofs_r <= diff[OFS_W-1:0];
      end
      if (p_idx_r == '0 || new_score < best_r) begin
        best_r   <= new_score;
        victim_r <= p_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      score_q <= score_mem[cnt_r[IDX_W-1:0]];
      tag_q   <= tag_mem[cnt_r[IDX_W-1:0]];
    end
    if (sc_wr_en) begin
      score_mem[sc_wr_addr] <= sc_wr_data;
    end
    if (alloc_wr) begin
      tag_mem[victim_r] <= aligned;
    end
  end

  // entries whose score was never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      sc_init_r <= '0;
    end else begin
      if (scan_wr) sc_init_r[p_idx_r] <= 1'b1;
      if (alloc_wr) ent_vld_r[victim_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r   <= hit_r;
      out_slot_r  <= hit_r ? slot_t'(match_idx_r) : slot_t'(victim_r);
      out_ofs_r   <= hit_r ? match_ofs_r : (sector_r[OFS_W-1:0] & lo_mask);
      out_fetch_r <= hit_r ? sector_t'(0) : aligned;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_sector_offset = out_ofs_r;
  assign out_fetch_sector  = out_fetch_r;

endmodule

// ----- test/tb_sector_cache_directory_top.sv -----
`timescale 1ns / 100ps
module tb_sector_cache_directory_top;
  import scd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOT_BLOCKS = 48;
  localparam int PHASE_ITEMS = 366;
  localparam cfg_addr_t ADDR_LOG2 = cfg_addr_t'({REG_BLOCK_SECTORS_LOG2, 2'b00});
  localparam cfg_addr_t ADDR_UNUSED =
    cfg_addr_t'({REG_BLOCK_SECTORS_LOG2 + reg_idx_t'(1), 2'b00});

  typedef struct packed {
    logic    hit;
    slot_t   slot;
    ofs_t    sector_offset;
    sector_t fetch_sector;
  } lookup_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sector_t   in_sector = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      out_hit;
  slot_t     out_slot;
  ofs_t      out_sector_offset;
  sector_t   out_fetch_sector;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  cfg_addr_t paddr = '0;
  cfg_data_t pwdata = '0;
  cfg_data_t prdata;
  logic      pready;

  // directory mirror
  sector_t tag_q[ENTRIES];
  logic    tag_valid[ENTRIES];
  score_t  score_q[ENTRIES];
  log2_t   blk_log2;

  lookup_t pending[$];
  int      errors = 0;
  int      idle_cycles = 0;
  logic    quiet = 1'b0;

  sector_cache_directory_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sector         (in_sector),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_sector_offset (out_sector_offset),
    .out_fetch_sector  (out_fetch_sector),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  function automatic int clip_score(int v);
    if (v > int'(SCORE_MAX)) return int'(SCORE_MAX);
    if (v < int'(SCORE_MIN)) return int'(SCORE_MIN);
    return v;
  endfunction

  function automatic lookup_t predict_lookup(sector_t s);
    lookup_t     r;
    logic [32:0] span;
    sector_t     mask;
    sector_t     aligned;
    int          hit_idx;
    int          victim;
    int          sc;
    int          i;
    span = 33'd1 << blk_log2;
    mask = sector_t'(span - 33'd1);
    hit_idx = -1;
    for (i = 0; i < ENTRIES; i++) begin
      sc = int'(score_q[i]);
      if (tag_valid[i] && s >= tag_q[i] && {1'b0, s} < {1'b0, tag_q[i]} + span) begin
        if (sc < 0) sc = 0;
        sc = clip_score(sc + 2);
        hit_idx = i;
      end
      score_q[i] = score_t'(clip_score(sc - 1));
    end
    if (hit_idx >= 0) begin
      r.hit = 1'b1;
      r.slot = slot_t'(hit_idx);
      r.sector_offset = ofs_t'(s - tag_q[hit_idx]);
      r.fetch_sector = '0;
      return r;
    end
    victim = 0;
    for (i = 1; i < ENTRIES; i++) begin
      if (score_q[i] < score_q[victim]) victim = i;
    end
    score_q[victim] = score_t'(clip_score(int'(score_q[victim]) + 2));
    aligned = s & ~mask;
    tag_q[victim] = aligned;
    tag_valid[victim] = 1'b1;
    r.hit = 1'b0;
    r.slot = slot_t'(victim);
    r.sector_offset = ofs_t'(s & mask);
    r.fetch_sector = aligned;
    return r;
  endfunction

  task automatic send_request(input sector_t s);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(45, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sector <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(predict_lookup(s));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input cfg_addr_t addr, input cfg_data_t data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      if (addr[CFG_AW-1:2] == REG_BLOCK_SECTORS_LOG2) blk_log2 = log2_t'(data);
    end else if (prdata !== cfg_data_t'(blk_log2)) begin
      $error("prdata: expected %h actual %h", cfg_data_t'(blk_log2), prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_block_size();
    cfg_access(1'b0, ADDR_LOG2, '0);
    send_request(32'h0000_0000);
    send_request(32'h0000_0007);
    send_request(32'h0000_0008);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFF8);
    send_request(32'hFFFF_FFF0);
    send_request(32'h0FFF_FFFF);
    send_request(32'h8000_0000);
    wait_idle();
  endtask

  task automatic test_register_writes();
    cfg_access(1'b1, ADDR_UNUSED, $urandom());
    cfg_access(1'b0, ADDR_LOG2, '0);
    cfg_access(1'b1, ADDR_LOG2, 32'hFFFF_FFFC);
    cfg_access(1'b0, ADDR_LOG2, '0);
    cfg_access(1'b1, ADDR_LOG2, 32'h5555_5551);
    cfg_access(1'b0, ADDR_LOG2, '0);
    cfg_access(1'b1, ADDR_LOG2, 32'hAAAA_AAAA);
    cfg_access(1'b0, ADDR_LOG2, '0);
    cfg_access(1'b1, ADDR_LOG2, 32'h0000_0003);
    cfg_access(1'b0, ADDR_LOG2, '0);
  endtask

  // blocks allocated at one size overlap once the size grows
  task automatic test_overlapping_blocks();
    cfg_access(1'b1, ADDR_LOG2, 32'd0);
    send_request(32'd100);
    send_request(32'd101);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF);
    wait_idle();
    cfg_access(1'b1, ADDR_LOG2, 32'd3);
    send_request(32'd101);
    send_request(32'd105);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFC);
    wait_idle();
    cfg_access(1'b1, ADDR_LOG2, 32'd2);
    send_request(32'd103);
    send_request(32'd96);
    wait_idle();
    cfg_access(1'b1, ADDR_LOG2, 32'd1);
    send_request(32'd98);
    send_request(32'd1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    log2_t   sizes[5];
    sector_t hot[HOT_BLOCKS];
    sector_t s;
    sector_t prev;
    int      p;
    int      k;
    int      r;
    sizes = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
    prev = '0;
    for (p = 0; p < 5; p++) begin
      cfg_access(1'b1, ADDR_UNUSED, $urandom());
      cfg_access(1'b1, ADDR_LOG2, {30'($urandom_range(32'h3FFF_FFFF)), sizes[p]});
      cfg_access(1'b0, ADDR_LOG2, '0);
      for (k = 0; k < HOT_BLOCKS; k++) begin
        case ($urandom_range(3))
          0: hot[k] = $urandom();
          1: hot[k] = $urandom_range(255);
          2: hot[k] = 32'hFFFF_FF00 | $urandom_range(255);
          default: hot[k] = $urandom() & 32'h0000_FFFF;
        endcase
      end
      quiet = (p == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 70) s = hot[$urandom_range(HOT_BLOCKS - 1)] + $urandom_range(7);
        else if (r < 85) s = prev ^ $urandom_range(15);
        else s = $urandom();
        send_request(s);
        prev = s;
      end
      wait_idle();
      quiet = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    lookup_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = pending.pop_front();
        if (out_hit !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, out_hit);
          errors++;
        end
        if (out_slot !== exp_r.slot) begin
          $error("slot: expected %0d actual %0d", exp_r.slot, out_slot);
          errors++;
        end
        if (out_sector_offset !== exp_r.sector_offset) begin
          $error("sector_offset: expected %0d actual %0d", exp_r.sector_offset,
                 out_sector_offset);
          errors++;
        end
        if (out_fetch_sector !== exp_r.fetch_sector) begin
          $error("fetch_sector: expected %h actual %h", exp_r.fetch_sector,
                 out_fetch_sector);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL sector_cache_directory_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      tag_q[i] = '0;
      tag_valid[i] = 1'b0;
      score_q[i] = '0;
    end
    blk_log2 = LOG2_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_block_size();
    test_register_writes();
    test_overlapping_blocks();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sector_cache_directory_top");
    end else begin
      $display("FAIL sector_cache_directory_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/scd_pkg.sv
design/scd_cfg.sv
design/sector_cache_directory_top.sv
test/tb_sector_cache_directory_top.sv
